[rtl/scba_pkg.sv]
// Shared types, constants and helper functions for the size-class block allocator.
package scba_pkg;

  // Pool geometry
  localparam int unsigned BLOCK_COUNT = 248;
  localparam int unsigned CHUNK_W     = 32;
  localparam int unsigned NUM_CHUNKS  = 8;
  localparam int unsigned PAD_W       = NUM_CHUNKS * CHUNK_W - BLOCK_COUNT;
  localparam int unsigned MAX_REQUEST = 2048;

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GRANT,
    S_FREE_SUB,
    S_FREE_CHK,
    S_DONE
  } state_e;

  // Control into the address unit
  typedef struct packed {
    logic sub;    // 1: address minus base, 0: base plus block offset
  } addr_ctrl_t;

  // Address decode result: which block an offset names
  typedef struct packed {
    logic       hit;
    logic [7:0] blk;
  } addr_res_t;

  // First block of the smallest class holding bytes (1..2048)
  function automatic logic [7:0] class_start(input logic [15:0] bytes);
    logic [7:0] s;
    if (bytes <= 16'd128)       s = 8'd0;
    else if (bytes <= 16'd256)  s = 8'd128;
    else if (bytes <= 16'd512)  s = 8'd192;
    else if (bytes <= 16'd1024) s = 8'd224;
    else                        s = 8'd240;
    return s;
  endfunction

  // Byte offset of block n from the heap base
  function automatic logic [16:0] block_offset(input logic [7:0] n);
    logic [16:0] o;
    if (n < 8'd128)      o = {3'b000, n[6:0], 7'b0};
    else if (n < 8'd192) o = {3'b001, n[5:0], 8'b0};
    else if (n < 8'd224) o = {3'b010, n[4:0], 9'b0};
    else if (n < 8'd240) o = {3'b011, n[3:0], 10'b0};
    else                 o = {3'b100, n[2:0], 11'b0};
    return o;
  endfunction

endpackage

[rtl/scba_scan.sv]
// Chunk scanner: lowest free block in one 32-bit slice of the free map.
module scba_scan (
  input  logic [31:0] word_i,
  input  logic [4:0]  low_i,
  output logic        found_o,
  output logic [4:0]  idx_o
);

  logic [31:0] masked;

  // drop blocks below the class start
  assign masked  = word_i & ({32{1'b1}} << low_i);
  assign found_o = |masked;

  // priority encoder, lowest bit wins
  always_comb begin
    idx_o = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (masked[i]) idx_o = 5'(i);
    end
  end

endmodule

[rtl/scba_addr.sv]
// Shared address adder plus offset-to-block decode.
module scba_addr (
  input  scba_pkg::addr_ctrl_t ctrl_i,
  input  logic [31:0]          base_i,
  input  logic [31:0]          addr_i,
  input  logic [7:0]           idx_i,
  input  logic [31:0]          delta_i,
  output logic [31:0]          sum_o,
  output scba_pkg::addr_res_t  res_o
);

  logic [31:0] op_a;
  logic [31:0] op_b;

  // one adder: base + offset(idx) for grants, addr - base for frees
  assign op_a  = ctrl_i.sub ? addr_i : {15'b0, scba_pkg::block_offset(idx_i)};
  assign op_b  = ctrl_i.sub ? ~base_i : base_i;
  assign sum_o = op_a + op_b + {31'b0, ctrl_i.sub};

  // offset to block number; region picked by bits 16:14
  always_comb begin
    res_o.hit = 1'b0;
    res_o.blk = 8'd0;
    if (delta_i[31:17] == 15'd0) begin
      case (delta_i[16:14])
        3'd0: begin
          res_o.hit = (delta_i[6:0] == 7'd0);
          res_o.blk = {1'b0, delta_i[13:7]};
        end
        3'd1: begin
          res_o.hit = (delta_i[7:0] == 8'd0);
          res_o.blk = {2'b10, delta_i[13:8]};
        end
        3'd2: begin
          res_o.hit = (delta_i[8:0] == 9'd0);
          res_o.blk = {3'b110, delta_i[13:9]};
        end
        3'd3: begin
          res_o.hit = (delta_i[9:0] == 10'd0);
          res_o.blk = {4'b1110, delta_i[13:10]};
        end
        3'd4: begin
          res_o.hit = (delta_i[10:0] == 11'd0);
          res_o.blk = {5'b11110, delta_i[13:11]};
        end
        default: begin
          res_o.hit = 1'b0;
          res_o.blk = 8'd0;
        end
      endcase
    end
  end

endmodule

[rtl/size_class_block_allocator_unit.sv]
// Top level of the size-class block allocator: sequencer, free map and result register.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      cmd_i, request_bytes_i, block_address_i
//   out      output     out_valid_o / out_stall_i    status_o, granted_address_o
//   cfg      input      heap_base_we_i               heap_base_wdata_i
//
// Allocate: accept, then scan 1 to 8 chunks (one 32-block chunk of the
// free map per cycle through the shared priority encoder), then grant on
// the shared adder; a bad size goes straight to the result.
// Free: accept, subtract on the shared adder, then decode and check.
// Reset marks every block free at once. One item at a time: in_stall_o is
// high from acceptance until the result has been taken.
module size_class_block_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        heap_base_we_i,
  input  logic [31:0] heap_base_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] request_bytes_i,
  input  logic [31:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] granted_address_o
);

  scba_pkg::state_e  state_q, state_d;
  scba_pkg::status_e status_q, status_d;
  logic [scba_pkg::BLOCK_COUNT-1:0] map_q, map_d;
  logic [31:0] base_q;
  logic [31:0] addr_q, addr_d;
  logic [31:0] delta_q, delta_d;
  logic [31:0] granted_q, granted_d;
  logic [2:0]  chunk_q, chunk_d;
  logic [4:0]  low_q, low_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  start;

  logic [scba_pkg::NUM_CHUNKS*scba_pkg::CHUNK_W-1:0] map_pad;
  logic [31:0] scan_word;
  logic        scan_found;
  logic [4:0]  scan_idx;
  logic [7:0]  scan_blk;

  scba_pkg::addr_ctrl_t addr_ctrl;
  scba_pkg::addr_res_t  addr_res;
  logic [31:0]          addr_sum;

  logic in_acc;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != scba_pkg::S_IDLE);
  assign out_valid_o = (state_q == scba_pkg::S_DONE);
  assign status_o    = status_q;
  assign granted_address_o = granted_q;

  // chunk of the free map under scan; blocks past the pool read as taken
  assign map_pad   = {{scba_pkg::PAD_W{1'b0}}, map_q};
  assign scan_word = map_pad[{chunk_q, 5'b0} +: scba_pkg::CHUNK_W];
  assign scan_blk  = {chunk_q, scan_idx};
  assign start     = scba_pkg::class_start(request_bytes_i);

  scba_scan u_scan (
    .word_i  (scan_word),
    .low_i   (low_q),
    .found_o (scan_found),
    .idx_o   (scan_idx)
  );

  assign addr_ctrl.sub = (state_q == scba_pkg::S_FREE_SUB);

  scba_addr u_addr (
    .ctrl_i  (addr_ctrl),
    .base_i  (base_q),
    .addr_i  (addr_q),
    .idx_i   (idx_q),
    .delta_i (delta_q),
    .sum_o   (addr_sum),
    .res_o   (addr_res)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    map_d     = map_q;
    addr_d    = addr_q;
    delta_d   = delta_q;
    granted_d = granted_q;
    chunk_d   = chunk_q;
    low_d     = low_q;
    idx_d     = idx_q;
    case (state_q)
      scba_pkg::S_IDLE: begin
        if (in_acc) begin
          addr_d = block_address_i;
          if (cmd_i == scba_pkg::CMD_FREE) begin
            state_d = scba_pkg::S_FREE_SUB;
          end else if (request_bytes_i == 16'd0 ||
                       request_bytes_i > 16'(scba_pkg::MAX_REQUEST)) begin
            status_d  = scba_pkg::ST_BAD_SIZE;
            granted_d = 32'd0;
            state_d   = scba_pkg::S_DONE;
          end else begin
            chunk_d = start[7:5];
            low_d   = start[4:0];
            state_d = scba_pkg::S_SCAN;
          end
        end
      end
      scba_pkg::S_SCAN: begin
        if (scan_found) begin
          idx_d           = scan_blk;
          map_d[scan_blk] = 1'b0;
          state_d         = scba_pkg::S_GRANT;
        end else if (chunk_q == 3'(scba_pkg::NUM_CHUNKS - 1)) begin
          status_d  = scba_pkg::ST_NO_BLOCK;
          granted_d = 32'd0;
          state_d   = scba_pkg::S_DONE;
        end else begin
          chunk_d = chunk_q + 3'd1;
          low_d   = 5'd0;
        end
      end
      scba_pkg::S_GRANT: begin
        granted_d = addr_sum;
        status_d  = scba_pkg::ST_OK;
        state_d   = scba_pkg::S_DONE;
      end
      scba_pkg::S_FREE_SUB: begin
        delta_d = addr_sum;
        state_d = scba_pkg::S_FREE_CHK;
      end
      scba_pkg::S_FREE_CHK: begin
        granted_d = 32'd0;
        if (addr_res.hit && !map_q[addr_res.blk]) begin
          map_d[addr_res.blk] = 1'b1;
          status_d = scba_pkg::ST_OK;
        end else begin
          status_d = scba_pkg::ST_NOT_ALLOC;
        end
        state_d = scba_pkg::S_DONE;
      end
      scba_pkg::S_DONE: begin
        if (!out_stall_i) state_d = scba_pkg::S_IDLE;
      end
      default: begin
        state_d = scba_pkg::S_IDLE;
      end
    endcase
  end

  // control state and free map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scba_pkg::S_IDLE;
      map_q   <= {scba_pkg::BLOCK_COUNT{1'b1}};
      base_q  <= 32'd0;
    end else begin
      state_q <= state_d;
      map_q   <= map_d;
      if (heap_base_we_i) base_q <= heap_base_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    addr_q    <= addr_d;
    delta_q   <= delta_d;
    granted_q <= granted_d;
    chunk_q   <= chunk_d;
    low_q     <= low_d;
    idx_q     <= idx_d;
  end

  // an accepted item always leaves idle
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != scba_pkg::S_IDLE)
    else $error("accepted item did not start work");

  // failed results carry a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != scba_pkg::ST_OK |-> granted_address_o == 32'd0)
    else $error("failed result with nonzero address");

  // at most one block changes hands per cycle
  a_map_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(map_q) <= $countones($past(map_q)) + 1 &&
    $countones(map_q) + 1 >= $countones($past(map_q)))
    else $error("free map changed by more than one block");

  // block being granted is marked taken
  a_grant_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scba_pkg::S_GRANT |-> !map_q[idx_q])
    else $error("granted block still marked free");

endmodule

[tb/tb_size_class_block_allocator_unit.sv]
// Self-checking testbench for the size-class block allocator: directed, random and stall tests.
`timescale 1ns / 100ps

module tb_size_class_block_allocator_unit;

  localparam logic [31:0] MAX_HEAP_BASE  = 32'hFFFE_BFFF;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam int unsigned BURST_ITEMS    = 150;
  localparam int unsigned RX_HOLD_CYCLES = 100;
  localparam int unsigned END_SETTLE     = 16;
  // Slowest item is a gap, a scan of all chunks and a stall; the long
  // receiver hold-off is the longest legal quiet stretch.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    scba_pkg::status_e status;
    logic [31:0]       addr;
  } alloc_result_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        heap_base_we_i    = 1'b0;
  logic [31:0] heap_base_wdata_i = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic        cmd_i             = 1'b0;
  logic [15:0] request_bytes_i   = '0;
  logic [31:0] block_address_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] granted_address_o;

  // Predictor state: one free bit per block and the heap base
  bit [scba_pkg::BLOCK_COUNT-1:0] pool_free = '1;
  logic [31:0]                    heap_base = '0;

  alloc_result_t expected_results[$];

  bit          tx_gaps_on      = 1'b1;
  bit          rx_gaps_on      = 1'b1;
  int unsigned rx_hold_request = 0;
  int unsigned fail_count      = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent      = 0;
  int unsigned config_writes   = 0;
  int unsigned idle_cycles     = 0;
  int unsigned status_tally [4];

  size_class_block_allocator_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .heap_base_we_i    (heap_base_we_i),
    .heap_base_wdata_i (heap_base_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o)
  );

  // Clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Class k holds 128 >> k blocks of 128 << k bytes, so it starts at 256 - (256 >> k)
  function automatic int unsigned first_block(input int unsigned k);
    return 256 - (256 >> k);
  endfunction

  // Every class spans 0x4000 bytes of the pool
  function automatic logic [31:0] block_start(input int unsigned n);
    int unsigned k;
    k = 0;
    while (k < 4 && n >= first_block(k + 1)) k++;
    return heap_base + k * 32'h4000 + (n - first_block(k)) * (128 << k);
  endfunction

  // Works out the result of one item and applies it to the free map
  function automatic alloc_result_t predict_pool_op(input scba_pkg::cmd_e cmd,
                                                    input logic [15:0] bytes,
                                                    input logic [31:0] addr);
    alloc_result_t r;
    int unsigned   k;
    bit            done;
    r.addr = '0;
    done   = 1'b0;
    if (cmd == scba_pkg::CMD_ALLOC) begin
      if (bytes == 0 || bytes > scba_pkg::MAX_REQUEST) begin
        r.status = scba_pkg::ST_BAD_SIZE;
      end else begin
        r.status = scba_pkg::ST_NO_BLOCK;
        k = 0;
        while (bytes > (128 << k)) k++;
        // lowest free block from the fitting class upwards
        for (int unsigned n = first_block(k); n < scba_pkg::BLOCK_COUNT && !done; n++) begin
          if (pool_free[n]) begin
            pool_free[n] = 1'b0;
            r.status     = scba_pkg::ST_OK;
            r.addr       = block_start(n);
            done         = 1'b1;
          end
        end
      end
    end else begin
      r.status = scba_pkg::ST_NOT_ALLOC;
      for (int unsigned n = 0; n < scba_pkg::BLOCK_COUNT && !done; n++) begin
        if (!pool_free[n] && block_start(n) == addr) begin
          pool_free[n] = 1'b1;
          r.status     = scba_pkg::ST_OK;
          done         = 1'b1;
        end
      end
    end
    status_tally[r.status]++;
    return r;
  endfunction

  // Random block that is free (want_free) or held; -1 when there is none
  function automatic int pick_block(input bit want_free);
    int candidates[$];
    for (int n = 0; n < scba_pkg::BLOCK_COUNT; n++)
      if (pool_free[n] == want_free) candidates.push_back(n);
    if (candidates.size() == 0) return -1;
    return candidates[$urandom_range(candidates.size() - 1)];
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (fail_count < 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    fail_count++;
  endfunction

  // Offer one item; valid stays high after acceptance unless a gap follows
  task automatic send_item(input scba_pkg::cmd_e cmd, input logic [15:0] bytes,
                           input logic [31:0] addr);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    request_bytes_i <= bytes;
    block_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_results.push_back(predict_pool_op(cmd, bytes, addr));
    items_sent++;
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_heap_base(input logic [31:0] base);
    wait_for_idle();
    heap_base_we_i    <= 1'b1;
    heap_base_wdata_i <= base;
    @(posedge clk_i);
    heap_base_we_i <= 1'b0;
    heap_base = base;
    config_writes++;
  endtask

  // Mostly well-formed allocate/free traffic, with bad sizes and bogus frees mixed in
  task automatic send_random_item();
    int unsigned roll;
    int unsigned k;
    int          n;
    logic [15:0] bytes;
    logic [31:0] addr;
    roll  = $urandom_range(99);
    k     = $urandom_range(4);
    bytes = 16'($urandom);
    addr  = $urandom;
    n     = pick_block(1'b0);
    if (roll >= 50 && roll < 80 && n >= 0) begin
      send_item(scba_pkg::CMD_FREE, bytes, block_start(n));
    end else if (roll >= 80 && roll < 90) begin
      case ($urandom_range(2))
        0: addr = $urandom;
        1: if (n >= 0) addr = block_start(n) + $urandom_range(1, 127);
        default: begin
          n = pick_block(1'b1);
          if (n >= 0) addr = block_start(n);
        end
      endcase
      send_item(scba_pkg::CMD_FREE, bytes, addr);
    end else if (roll >= 90) begin
      bytes = $urandom_range(1) ? 16'd0 : 16'($urandom_range(2049, 65535));
      send_item(scba_pkg::CMD_ALLOC, bytes, addr);
    end else begin
      bytes = (k == 0) ? 16'($urandom_range(1, 128)) : 16'($urandom_range((64 << k) + 1, 128 << k));
      send_item(scba_pkg::CMD_ALLOC, bytes, addr);
    end
  endtask

  // Size boundaries of every class, bad sizes, reuse, double and misaligned frees
  task automatic test_directed_sizes();
    send_item(scba_pkg::CMD_ALLOC, 16'd0, 32'hFFFF_FFFF);
    send_item(scba_pkg::CMD_ALLOC, 16'hFFFF, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd2049, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd1, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd128, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd129, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd256, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd257, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd512, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd513, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd1024, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd1025, 32'h0);
    send_item(scba_pkg::CMD_ALLOC, 16'd2048, 32'h0);
    send_item(scba_pkg::CMD_FREE, 16'd0, 32'h0000_0080);
    send_item(scba_pkg::CMD_FREE, 16'd0, 32'h0000_0080);
    send_item(scba_pkg::CMD_ALLOC, 16'd100, 32'h0);
    send_item(scba_pkg::CMD_FREE, 16'd0, 32'h0000_4001);
    send_item(scba_pkg::CMD_FREE, 16'd0, 32'h0000_0100);
    send_item(scba_pkg::CMD_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(scba_pkg::CMD_FREE, 16'd0, 32'h0001_0800);
    send_item(scba_pkg::CMD_FREE, 16'd0, 32'h0000_0000);
  endtask

  // Fill the whole pool through the smallest class, overflow it, then empty it
  task automatic test_pool_exhaustion();
    int n;
    n = pick_block(1'b0);
    while (n >= 0) begin
      send_item(scba_pkg::CMD_FREE, 16'($urandom), block_start(n));
      n = pick_block(1'b0);
    end
    for (int unsigned i = 0; i < scba_pkg::BLOCK_COUNT; i++)
      send_item(scba_pkg::CMD_ALLOC, 16'($urandom_range(1, 128)), $urandom);
    send_item(scba_pkg::CMD_ALLOC, 16'd1, $urandom);
    send_item(scba_pkg::CMD_ALLOC, 16'd2048, $urandom);
    send_item(scba_pkg::CMD_ALLOC, 16'd600, $urandom);
    // a lone free block at the top is reached by a small request
    send_item(scba_pkg::CMD_FREE, 16'd0, block_start(scba_pkg::BLOCK_COUNT - 1));
    send_item(scba_pkg::CMD_ALLOC, 16'd1, $urandom);
    n = pick_block(1'b0);
    while (n >= 0) begin
      send_item(scba_pkg::CMD_FREE, 16'($urandom), block_start(n));
      n = pick_block(1'b0);
    end
  endtask

  // Random traffic under several heap bases, blocks carried over between them
  task automatic test_heap_base_phases();
    logic [31:0] base;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       base = MAX_HEAP_BASE;
        1:       base = $urandom_range(MAX_HEAP_BASE);
        2:       base = 32'h0000_0001;
        default: base = 32'h0;
      endcase
      write_heap_base(base);
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  // No gaps on either side
  task automatic test_back_to_back();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (BURST_ITEMS) send_random_item();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver holds off while items keep coming, so the block stalls its input
  task automatic test_input_backpressure();
    write_heap_base($urandom_range(MAX_HEAP_BASE));
    rx_hold_request = RX_HOLD_CYCLES;
    repeat (16) send_random_item();
  endtask

  // Result sink: checks each result, draws a stall per item, serves hold-offs
  initial begin : result_sink
    int unsigned   stall_left;
    int unsigned   hold_left;
    alloc_result_t want;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with none expected, status %0d, address %h",
                     $time, status_o, granted_address_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) note_mismatch("status", 32'(want.status), 32'(status_o));
          if (granted_address_o !== want.addr)
            note_mismatch("granted address", want.addr, granted_address_o);
          results_checked++;
        end
        stall_left = rx_gaps_on ? $urandom_range(4) : 0;
      end
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_sizes();
    test_pool_exhaustion();
    test_heap_base_phases();
    test_back_to_back();
    test_input_backpressure();
    wait_for_idle();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("Ran %0d items over %0d heap base settings, %0d results checked, %0d failures.",
             items_sent, config_writes, results_checked, fail_count);
    $display("Outcomes: %0d ok, %0d bad size, %0d pool empty, %0d unknown address.",
             status_tally[scba_pkg::ST_OK], status_tally[scba_pkg::ST_BAD_SIZE],
             status_tally[scba_pkg::ST_NO_BLOCK], status_tally[scba_pkg::ST_NOT_ALLOC]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
